/* hw/rtl/tcon_pkg.sv */
// ============================================================================
// tcon_pkg
// Shared types and constants of the text console with mouse cursor: item
// structs, item kind codes, controller states and controller/datapath links.
// ============================================================================
package tcon_pkg;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_CHAR       = 2'd0,
        KIND_MOUSE_ON   = 2'd1,
        KIND_MOUSE_MOVE = 2'd2,
        KIND_READ       = 2'd3
    } t_kind;

    // Character codes
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] SPACE_CODE   = 8'h20;

    // Mouse home position before limiting to the screen
    localparam int HOME_COL_RAW = 40;
    localparam int HOME_ROW_RAW = 12;

    // Input item
    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        char_code;
        logic signed [7:0] move_dx;
        logic signed [7:0] move_dy;
        logic [10:0]       cell_index;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [15:0] cell_word;
        logic [6:0]  text_col;
        logic [4:0]  text_row;
        logic [6:0]  mouse_col;
        logic [4:0]  mouse_row;
    } t_out_item;

    // Controller states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHAR,
        ST_CLEAR,
        ST_MHOME,
        ST_MRD_OLD,
        ST_MWR_OLD,
        ST_MRD_NEW,
        ST_MWR_NEW,
        ST_RD,
        ST_RESP
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch;        // capture the incoming item
        logic sweep_zero;   // clear one cell to zero and advance the sweep
        logic sweep_space;  // set one character to space and advance the sweep
        logic char_put;     // write character / newline, move the text cursor
        logic attr_rd;      // read the attribute under the mouse
        logic attr_wr;      // write back the swapped attribute
        logic ptr_home;     // move the mouse to its home position
        logic ptr_step;     // add the clamped offsets to the mouse position
        logic cell_rd;      // read the addressed cell
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic sweep_last;   // sweep sits on the last cell
        logic wrap_all;     // the pending character runs off the last row
    } t_status;

endpackage

/* hw/rtl/text_console_with_mouse_cursor.sv */
// ============================================================================
// text_console_with_mouse_cursor
// Text screen of 16-bit cells with a text cursor and a mouse cursor shown by
// swapping the attribute nibbles of the cell under it.
// ============================================================================
//
// Channel   Ports                      Handshake
// --------  -------------------------  ----------------------------------
// input     i_item (t_in_item)         taken when start high, busy low
// result    o_result (t_out_item)      one cycle, marked by o_valid
//
// States per item: character CHAR, RESP; read RD, RESP; mouse activate MHOME,
// MRD_NEW, MWR_NEW, RESP; mouse move MRD_OLD, MWR_OLD, MRD_NEW, MWR_NEW, RESP;
// set by the single-port character and attribute memories. A character that
// runs off the last row adds a sweep that turns every character into a space.
// After reset a clearing pass zeroes the screen; busy stays high until it
// ends. The receiver cannot stall the result.
// ============================================================================
module text_console_with_mouse_cursor #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  tcon_pkg::t_in_item  i_item,
    output logic                o_valid,
    output tcon_pkg::t_out_item o_result
);

    tcon_pkg::t_cmd    cmd;
    tcon_pkg::t_status status;

    // Sequencer
    tcon_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_kind   (i_item.kind),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_valid  (o_valid)
    );

    // Storage and arithmetic
    tcon_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (o_result)
    );

    // An accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // A result strobe lasts exactly one cycle
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // Results only while an item is in work
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while idle");

    // Cursor columns stay on the screen
    a_cols_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((32'(o_result.text_col) < COLUMNS) &&
                     (32'(o_result.mouse_col) < COLUMNS)))
        else $error("cursor column off the screen");

endmodule

/* hw/rtl/tcon_ctrl.sv */
// ============================================================================
// tcon_ctrl
// Controller of the text console: sequences the clearing sweeps, the
// character write, the mouse read-modify-write passes and the cell read.
// ============================================================================
module tcon_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [1:0]       i_kind,
    input  tcon_pkg::t_status i_status,
    output tcon_pkg::t_cmd   o_cmd,
    output logic             busy,
    output logic             o_valid
);

    tcon_pkg::t_state r_state;
    tcon_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcon_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcon_pkg::ST_INIT: begin
                if (i_status.sweep_last) n_state = tcon_pkg::ST_IDLE;
            end
            tcon_pkg::ST_IDLE: begin
                if (start) begin
                    unique case (i_kind)
                        tcon_pkg::KIND_CHAR:       n_state = tcon_pkg::ST_CHAR;
                        tcon_pkg::KIND_MOUSE_ON:   n_state = tcon_pkg::ST_MHOME;
                        tcon_pkg::KIND_MOUSE_MOVE: n_state = tcon_pkg::ST_MRD_OLD;
                        default:                   n_state = tcon_pkg::ST_RD;
                    endcase
                end
            end
            tcon_pkg::ST_CHAR: begin
                n_state = i_status.wrap_all ? tcon_pkg::ST_CLEAR : tcon_pkg::ST_RESP;
            end
            tcon_pkg::ST_CLEAR: begin
                if (i_status.sweep_last) n_state = tcon_pkg::ST_RESP;
            end
            tcon_pkg::ST_MHOME:   n_state = tcon_pkg::ST_MRD_NEW;
            tcon_pkg::ST_MRD_OLD: n_state = tcon_pkg::ST_MWR_OLD;
            tcon_pkg::ST_MWR_OLD: n_state = tcon_pkg::ST_MRD_NEW;
            tcon_pkg::ST_MRD_NEW: n_state = tcon_pkg::ST_MWR_NEW;
            tcon_pkg::ST_MWR_NEW: n_state = tcon_pkg::ST_RESP;
            tcon_pkg::ST_RD:      n_state = tcon_pkg::ST_RESP;
            tcon_pkg::ST_RESP:    n_state = tcon_pkg::ST_IDLE;
            default:              n_state = tcon_pkg::ST_INIT;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd   = '0;
        busy    = (r_state != tcon_pkg::ST_IDLE);
        o_valid = (r_state == tcon_pkg::ST_RESP);
        unique case (r_state)
            tcon_pkg::ST_INIT:    o_cmd.sweep_zero  = 1'b1;
            tcon_pkg::ST_IDLE:    o_cmd.latch       = start;
            tcon_pkg::ST_CHAR:    o_cmd.char_put    = 1'b1;
            tcon_pkg::ST_CLEAR:   o_cmd.sweep_space = 1'b1;
            tcon_pkg::ST_MHOME:   o_cmd.ptr_home    = 1'b1;
            tcon_pkg::ST_MRD_OLD: o_cmd.attr_rd     = 1'b1;
            tcon_pkg::ST_MWR_OLD: begin
                o_cmd.attr_wr  = 1'b1;
                o_cmd.ptr_step = 1'b1;
            end
            tcon_pkg::ST_MRD_NEW: o_cmd.attr_rd     = 1'b1;
            tcon_pkg::ST_MWR_NEW: o_cmd.attr_wr     = 1'b1;
            tcon_pkg::ST_RD:      o_cmd.cell_rd     = 1'b1;
            default:              o_cmd             = '0;
        endcase
    end

endmodule

/* hw/rtl/tcon_dp.sv */
// ============================================================================
// tcon_dp
// Datapath of the text console: character and attribute memories, text
// cursor, mouse position, clearing sweep counter and result assembly.
// ============================================================================
module tcon_dp #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcon_pkg::t_in_item i_item,
    input  tcon_pkg::t_cmd     i_cmd,
    output tcon_pkg::t_status  o_status,
    output tcon_pkg::t_out_item o_result
);

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int ROW_W    = $clog2(ROWS);
    localparam int HOME_COL = (tcon_pkg::HOME_COL_RAW < COLUMNS) ?
                              tcon_pkg::HOME_COL_RAW : COLUMNS - 1;
    localparam int HOME_ROW = (tcon_pkg::HOME_ROW_RAW < ROWS) ?
                              tcon_pkg::HOME_ROW_RAW : ROWS - 1;

    // Screen memories: character byte and attribute byte kept apart
    logic [7:0] mem_char [CELLS];
    logic [7:0] mem_attr [CELLS];

    tcon_pkg::t_in_item r_item;
    logic [COL_W-1:0]  r_cur_col;
    logic [ROW_W-1:0]  r_cur_row;
    logic [COL_W-1:0]  r_ptr_col;
    logic [ROW_W-1:0]  r_ptr_row;
    logic [ADDR_W-1:0] r_sweep;
    logic [7:0]        r_char_q;
    logic [7:0]        r_attr_q;
    logic              r_in_range;

    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] ptr_addr;
    logic [ADDR_W-1:0] read_addr;
    logic              read_ok;
    logic              newline;
    logic              col_wrap;
    logic              wrap_all;
    logic signed [9:0] sum_col;
    logic signed [9:0] sum_row;
    logic [COL_W-1:0]  step_col;
    logic [ROW_W-1:0]  step_row;

    logic              char_we;
    logic              char_re;
    logic [ADDR_W-1:0] char_addr;
    logic [7:0]        char_wdata;
    logic              attr_we;
    logic              attr_re;
    logic [ADDR_W-1:0] attr_addr;
    logic [7:0]        attr_wdata;

    // Cell addresses
    assign cur_addr  = ADDR_W'(r_cur_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_cur_col);
    assign ptr_addr  = ADDR_W'(r_ptr_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_ptr_col);
    assign read_addr = ADDR_W'(r_item.cell_index);
    assign read_ok   = (32'(r_item.cell_index) < CELLS);

    // Text cursor advance
    assign newline  = (r_item.char_code == tcon_pkg::NEWLINE_CODE);
    assign col_wrap = newline || (r_cur_col == COL_W'(COLUMNS - 1));
    assign wrap_all = col_wrap && (r_cur_row == ROW_W'(ROWS - 1));

    // Clamped mouse step
    assign sum_col = $signed(10'(r_ptr_col)) + 10'(r_item.move_dx);
    assign sum_row = $signed(10'(r_ptr_row)) + 10'(r_item.move_dy);

    always_comb begin
        if (sum_col < 10'sd0) begin
            step_col = '0;
        end else if (sum_col > $signed(10'(COLUMNS - 1))) begin
            step_col = COL_W'(COLUMNS - 1);
        end else begin
            step_col = sum_col[COL_W-1:0];
        end
        if (sum_row < 10'sd0) begin
            step_row = '0;
        end else if (sum_row > $signed(10'(ROWS - 1))) begin
            step_row = ROW_W'(ROWS - 1);
        end else begin
            step_row = sum_row[ROW_W-1:0];
        end
    end

    assign o_status.sweep_last = (r_sweep == ADDR_W'(CELLS - 1));
    assign o_status.wrap_all   = wrap_all;

    // Character memory port
    always_comb begin
        char_we    = 1'b0;
        char_re    = i_cmd.cell_rd;
        char_addr  = read_addr;
        char_wdata = r_item.char_code;
        if (i_cmd.sweep_zero || i_cmd.sweep_space) begin
            char_we    = 1'b1;
            char_addr  = r_sweep;
            char_wdata = i_cmd.sweep_space ? tcon_pkg::SPACE_CODE : 8'h00;
        end else if (i_cmd.char_put) begin
            char_we   = !newline;
            char_addr = cur_addr;
        end
    end

    // Attribute memory port
    always_comb begin
        attr_we    = 1'b0;
        attr_re    = i_cmd.cell_rd || i_cmd.attr_rd;
        attr_addr  = i_cmd.cell_rd ? read_addr : ptr_addr;
        attr_wdata = {r_attr_q[3:0], r_attr_q[7:4]};
        if (i_cmd.sweep_zero) begin
            attr_we    = 1'b1;
            attr_addr  = r_sweep;
            attr_wdata = 8'h00;
        end else if (i_cmd.attr_wr) begin
            attr_we = 1'b1;
        end
    end

    // Memories with registered read data
    always_ff @(posedge i_clk) begin
        if (char_we) mem_char[char_addr] <= char_wdata;
        if (char_re) r_char_q <= mem_char[char_addr];
    end

    always_ff @(posedge i_clk) begin
        if (attr_we) mem_attr[attr_addr] <= attr_wdata;
        if (attr_re) r_attr_q <= mem_attr[attr_addr];
    end

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) r_item <= i_item;
        if (i_cmd.cell_rd) r_in_range <= read_ok;
    end

    // Advance the sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep_zero || i_cmd.sweep_space) begin
            r_sweep <= o_status.sweep_last ? '0 : r_sweep + 1'b1;
        end
    end

    // Text cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= '0;
            r_cur_row <= '0;
        end else if (i_cmd.char_put) begin
            r_cur_col <= col_wrap ? '0 : r_cur_col + 1'b1;
            if (wrap_all) begin
                r_cur_row <= '0;
            end else if (col_wrap) begin
                r_cur_row <= r_cur_row + 1'b1;
            end
        end
    end

    // Mouse position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr_col <= COL_W'(HOME_COL);
            r_ptr_row <= ROW_W'(HOME_ROW);
        end else if (i_cmd.ptr_home) begin
            r_ptr_col <= COL_W'(HOME_COL);
            r_ptr_row <= ROW_W'(HOME_ROW);
        end else if (i_cmd.ptr_step) begin
            r_ptr_col <= step_col;
            r_ptr_row <= step_row;
        end
    end

    // Result assembly
    always_comb begin
        o_result.cell_word = '0;
        if ((r_item.kind == tcon_pkg::KIND_READ) && r_in_range) begin
            o_result.cell_word = {r_attr_q, r_char_q};
        end
        o_result.text_col  = 7'(r_cur_col);
        o_result.text_row  = 5'(r_cur_row);
        o_result.mouse_col = 7'(r_ptr_col);
        o_result.mouse_row = 5'(r_ptr_row);
    end

endmodule

/* tb/text_console_with_mouse_cursor_tb.sv */
// ============================================================================
// text_console_with_mouse_cursor_tb
// Self-checking bench for the text console with mouse cursor. A mirror of the
// screen, text cursor and mouse position is kept alongside the block. Every
// item taken by the block updates the mirror, and the status report that the
// mirror gives is queued. Each report strobed out of the block is compared
// field by field with the oldest queued one. Directed items come first, then
// random sequences of text runs, newline bursts, mouse moves, reads and noise
// under several sender idling phases.
// ============================================================================
module text_console_with_mouse_cursor_tb;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int HOME_COL    = (tcon_pkg::HOME_COL_RAW < COLUMNS) ?
                                 tcon_pkg::HOME_COL_RAW : COLUMNS - 1;
    localparam int HOME_ROW    = (tcon_pkg::HOME_ROW_RAW < ROWS) ?
                                 tcon_pkg::HOME_ROW_RAW : ROWS - 1;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASE_ITEMS = 435;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    tcon_pkg::t_in_item  i_item  = '0;
    logic                busy;
    logic                o_valid;
    tcon_pkg::t_out_item o_result;

    // Mirror of the console state
    logic [15:0] screen_mirror [CELLS];
    int          cur_col;
    int          cur_row;
    int          ptr_col;
    int          ptr_row;

    tcon_pkg::t_out_item reports_due [$];
    int                  error_count = 0;
    int                  items_sent  = 0;
    int                  idle_pct    = 0;
    int                  cycle_count = 0;

    text_console_with_mouse_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Console mirror
    // ------------------------------------------------------------------

    // Swap the attribute nibbles of the cell under the mouse
    function automatic void toggle_pointer_cell();
        int          idx;
        logic [15:0] v;
        idx = ptr_row * COLUMNS + ptr_col;
        if (idx < CELLS) begin
            v = screen_mirror[idx];
            screen_mirror[idx] = {v[11:8], v[15:12], v[7:0]};
        end
    endfunction

    function automatic int clamp_step(int pos, int off, int lim);
        int t;
        t = pos + off;
        if (t < 0) t = 0;
        if (t > lim - 1) t = lim - 1;
        return t;
    endfunction

    // Place one character, wrap the cursor, blank the screen past the last row
    function automatic void put_text_char(logic [7:0] code);
        int idx;
        if (code == tcon_pkg::NEWLINE_CODE) begin
            cur_col = 0;
            cur_row++;
        end else begin
            idx = cur_row * COLUMNS + cur_col;
            if (idx < CELLS) screen_mirror[idx][7:0] = code;
            cur_col++;
        end
        if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= ROWS) begin
            for (int i = 0; i < CELLS; i++) screen_mirror[i][7:0] = tcon_pkg::SPACE_CODE;
            cur_col = 0;
            cur_row = 0;
        end
    endfunction

    // Apply one item to the mirror and return the status report it gives
    function automatic tcon_pkg::t_out_item console_apply(tcon_pkg::t_in_item it);
        tcon_pkg::t_out_item rep;
        int                  idx;
        rep = '0;
        case (tcon_pkg::t_kind'(it.kind))
            tcon_pkg::KIND_CHAR: put_text_char(it.char_code);
            tcon_pkg::KIND_MOUSE_ON: begin
                ptr_col = HOME_COL;
                ptr_row = HOME_ROW;
                toggle_pointer_cell();
            end
            tcon_pkg::KIND_MOUSE_MOVE: begin
                toggle_pointer_cell();
                ptr_col = clamp_step(ptr_col, int'($signed(it.move_dx)), COLUMNS);
                ptr_row = clamp_step(ptr_row, int'($signed(it.move_dy)), ROWS);
                toggle_pointer_cell();
            end
            default: begin
                idx = int'(it.cell_index);
                if (idx < CELLS) rep.cell_word = screen_mirror[idx];
            end
        endcase
        rep.text_col  = 7'(cur_col);
        rep.text_row  = 5'(cur_row);
        rep.mouse_col = 7'(ptr_col);
        rep.mouse_row = 5'(ptr_row);
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Item building and sending
    // ------------------------------------------------------------------

    // Item of the given kind with random content in the unused fields
    function automatic tcon_pkg::t_in_item item_of(tcon_pkg::t_kind k);
        logic [63:0]        r;
        tcon_pkg::t_in_item it;
        r = {$urandom, $urandom};
        it = r[36:0];
        it.kind = k;
        return it;
    endfunction

    // Hold start, wait for the block to take the item, then queue its report
    task automatic send_item(tcon_pkg::t_in_item it);
        logic [63:0] noise;
        if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
            noise = {$urandom, $urandom};
            start  <= 1'b0;
            i_item <= noise[36:0];
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_item <= it;
        start  <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        reports_due.push_back(console_apply(it));
        items_sent++;
    endtask

    task automatic send_char(logic [7:0] code);
        tcon_pkg::t_in_item it;
        it = item_of(tcon_pkg::KIND_CHAR);
        it.char_code = code;
        send_item(it);
    endtask

    task automatic send_move(logic [7:0] dx, logic [7:0] dy);
        tcon_pkg::t_in_item it;
        it = item_of(tcon_pkg::KIND_MOUSE_MOVE);
        it.move_dx = dx;
        it.move_dy = dy;
        send_item(it);
    endtask

    task automatic send_read(int idx);
        tcon_pkg::t_in_item it;
        it = item_of(tcon_pkg::KIND_READ);
        it.cell_index = 11'(idx);
        send_item(it);
    endtask

    // Drop start and hold off until every queued report has come back
    task automatic drain_reports();
        start <= 1'b0;
        do @(posedge i_clk); while (reports_due.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Report checking
    // ------------------------------------------------------------------

    function automatic void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            error_count++;
        end
    endfunction

    // Compare each strobed report with the oldest queued one
    always @(posedge i_clk) begin
        tcon_pkg::t_out_item due;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (reports_due.size() == 0) begin
                $error("report strobed with no item awaiting it");
                error_count++;
            end else begin
                due = reports_due.pop_front();
                check_field("cell_word", due.cell_word, o_result.cell_word);
                check_field("text_col", due.text_col, o_result.text_col);
                check_field("text_row", due.text_row, o_result.text_row);
                check_field("mouse_col", due.mouse_col, o_result.mouse_col);
                check_field("mouse_row", due.mouse_row, o_result.mouse_row);
            end
        end
    end

    // ------------------------------------------------------------------
    // Random picks
    // ------------------------------------------------------------------

    // Any byte except newline
    function automatic logic [7:0] pick_text_byte();
        int c;
        c = $urandom_range(0, 254);
        if (c >= tcon_pkg::NEWLINE_CODE) c++;
        return 8'(c);
    endfunction

    // Small steps mostly, some full-scale offsets to pin the mouse at an edge
    function automatic logic [7:0] pick_offset();
        case ($urandom_range(0, 3))
            0, 1:    return 8'($urandom_range(0, 6) - 3);
            2:       return $urandom_range(0, 1) ? 8'h7F : 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Cells just written, under the mouse, anywhere, or off the screen
    function automatic int pick_read_index();
        int idx;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                idx = cur_row * COLUMNS + cur_col - $urandom_range(0, 4);
                if (idx < 0) idx = 0;
            end
            4, 5:    idx = ptr_row * COLUMNS + ptr_col;
            6, 7, 8: idx = $urandom_range(0, CELLS - 1);
            default: idx = $urandom_range(CELLS, 2047);
        endcase
        return idx;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Cleared screen, both ends and the off-screen range
    task automatic test_reads_after_reset();
        send_read(0);
        send_read(2047);
        send_read(CELLS - 1);
        send_read(CELLS);
    endtask

    // Mouse moves from the reset position, saturating at both corners
    task automatic test_move_without_activate();
        send_move(8'h00, 8'h00);
        send_move(8'h7F, 8'h7F);
        send_move(8'h80, 8'h80);
        send_move(8'h01, 8'hFF);
    endtask

    // Second activate swaps the home cell again
    task automatic test_mouse_activate();
        send_item(item_of(tcon_pkg::KIND_MOUSE_ON));
        send_item(item_of(tcon_pkg::KIND_MOUSE_ON));
    endtask

    // Zero byte, all-ones byte, plain letter, newline, space
    task automatic test_char_codes();
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h41);
        send_char(tcon_pkg::NEWLINE_CODE);
        send_char(tcon_pkg::SPACE_CODE);
    endtask

    task automatic test_read_back();
        send_read(0);
        send_read(1);
        send_read(2);
        send_read(COLUMNS);
        send_read(HOME_ROW * COLUMNS + HOME_COL);
        send_read(ptr_row * COLUMNS + ptr_col);
    endtask

    // Random sequences until the item count for this phase is reached
    task automatic test_random_traffic(int n_items, int pct);
        int stop_at;
        int len;
        int nl_pct;
        idle_pct = pct;
        stop_at  = items_sent + n_items;
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 19))
                // text run, long ones wrap the column
                0, 1, 2, 3, 4, 5, 6: begin
                    len    = $urandom_range(1, 90);
                    nl_pct = $urandom_range(0, 1) ? 10 : 0;
                    repeat (len) begin
                        if ($urandom_range(1, 100) <= nl_pct) begin
                            send_char(tcon_pkg::NEWLINE_CODE);
                        end else begin
                            send_char(pick_text_byte());
                        end
                    end
                end
                // newline burst toward the bottom row and the blanking sweep
                7, 8: repeat ($urandom_range(1, 30)) send_char(tcon_pkg::NEWLINE_CODE);
                // mouse session
                9, 10, 11, 12, 13: begin
                    if ($urandom_range(0, 2) == 0) send_item(item_of(tcon_pkg::KIND_MOUSE_ON));
                    repeat ($urandom_range(1, 8)) send_move(pick_offset(), pick_offset());
                end
                // reads
                14, 15, 16, 17: repeat ($urandom_range(1, 10)) send_read(pick_read_index());
                // noise
                default: begin
                    repeat ($urandom_range(1, 5)) begin
                        logic [63:0] r;
                        r = {$urandom, $urandom};
                        send_item(r[36:0]);
                    end
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------

    // End the run if the block stops answering
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        for (int i = 0; i < CELLS; i++) screen_mirror[i] = '0;
        cur_col = 0;
        cur_row = 0;
        ptr_col = HOME_COL;
        ptr_row = HOME_ROW;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reads_after_reset();
        test_move_without_activate();
        test_mouse_activate();
        test_char_codes();
        test_read_back();
        drain_reports();

        test_random_traffic(PHASE_ITEMS, 0);
        drain_reports();
        test_random_traffic(PHASE_ITEMS, 52);
        test_random_traffic(PHASE_ITEMS, 0);
        drain_reports();
        test_random_traffic(PHASE_ITEMS, 19);

        drain_reports();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
